// ===== hdl/lfid_pkg.sv =====
// ----------------------------------------------------------------------------
// Lowest-free ID allocator package
// Shared constants, the bitmap row type and the lowest-free-bit search.
// ----------------------------------------------------------------------------
package lfid_pkg;

	localparam int ID_BITS  = 7;
	localparam int ROW_SH   = 3;
	localparam int ROW_BITS = 1 << ROW_SH;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_EXHAUSTED = 1'b1;

	typedef logic [ROW_BITS-1:0] row_t;

	typedef struct packed {
		logic              hit;
		logic [ROW_SH-1:0] pos;
	} find_t;

	// Lowest set bit of a row of free flags.
	function automatic find_t find_first(input row_t free_bits);
		find_t res;
		res.hit = 1'b0;
		res.pos = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				res.hit = 1'b1;
				res.pos = ROW_SH'(b);
			end
		end
		return res;
	endfunction

endpackage

// ===== hdl/lfid_bitmap.sv =====
// ----------------------------------------------------------------------------
// Lowest-free ID allocator bitmap store
// Row-wide used-flag memory with a registered read port, one write port and
// a clearing pass after reset.
// ----------------------------------------------------------------------------
module lfid_bitmap #(
	parameter int NROWS = 13,
	parameter int ROW_W = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ROW_W-1:0]     rd_row,
	output lfid_pkg::row_t       rd_data,
	input  logic                 wr_en,
	input  logic [ROW_W-1:0]     wr_row,
	input  lfid_pkg::row_t       wr_data,
	output logic                 ready
);
	import lfid_pkg::*;

	row_t             mem [NROWS];
	row_t             rd_data_q;
	logic             clearing_q;
	logic [ROW_W-1:0] clr_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			if (clr_row_q == ROW_W'(NROWS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_row_q <= ROW_W'(clr_row_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_row_q] <= '0;
		end else if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		rd_data_q <= mem[rd_row];
	end

	assign rd_data = rd_data_q;
	assign ready   = !clearing_q;

endmodule

// ===== hdl/lowest_free_id_allocator.sv =====
// ----------------------------------------------------------------------------
// Lowest-free ID allocator
// Grants the lowest free ID in 1..ID_LIMIT-1 or echoes a nonzero held_id, and
// takes IDs back; a hint register of the lowest free ID is rebuilt row by row.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (low bit first)
//  s_axis    in   tuser: func; tdata: held_id[6:0], pad
//  m_axis    out  tuser: status; tdata: granted_id[6:0], pad
//
// After reset the bitmap is cleared one row of eight IDs per cycle, with
// s_axis_tready low. An allocate served from the hint reads and updates
// one bitmap row, then scans one row per cycle for the new hint; a release
// reads and clears one bit. One item is in work at a time; a finished result
// waits in the output register while m_axis_tready is low.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator #(
	parameter int ID_LIMIT = 100
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // held_id[6:0], zero pad
	input  logic       s_axis_tuser,   // func
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // granted_id[6:0], zero pad
	output logic       m_axis_tuser    // status
);
	import lfid_pkg::*;

	localparam int NROWS = (ID_LIMIT + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int HW    = $clog2(ID_LIMIT + 1);
	localparam int ID_W  = (HW > ROW_W + ROW_SH) ? HW : ROW_W + ROW_SH;
	localparam int CMP_W = ((ID_W > ID_BITS) ? ID_W : ID_BITS) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ASET,
		ST_SCAN,
		ST_RCLR,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [ID_W-1:0]     hint_q;
	logic [ROW_W-1:0]    row_q;
	logic [ROW_SH-1:0]   pos_q;
	logic [ID_BITS-1:0]  res_id_q;
	logic                res_st_q;
	logic                m_valid_q;
	logic [ID_BITS-1:0]  m_id_q;
	logic                m_st_q;

	logic [ID_BITS-1:0]  held;
	logic                accept;
	logic                map_ready;
	logic [ROW_W-1:0]    rd_row;
	row_t                rd_data;
	logic                wr_en;
	row_t                wr_data;
	row_t                pos_bit;
	row_t                row_mask;
	row_t                ge_mask;
	row_t                free_bits;
	find_t               hit;
	logic [ROW_W-1:0]    row_nxt;
	logic                row_last;
	logic                hint_full;
	logic                held_in_range;
	logic [ROW_W-1:0]    hint_row;
	logic [ROW_W-1:0]    held_row;

	assign held          = s_axis_tdata[ID_BITS-1:0];
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && map_ready;

	assign hint_full     = (hint_q == ID_W'(ID_LIMIT));
	assign held_in_range = (held != '0) && (CMP_W'(held) < CMP_W'(ID_LIMIT));
	assign hint_row      = ROW_W'(hint_q >> ROW_SH);
	assign held_row      = ROW_W'(held >> ROW_SH);
	assign row_nxt       = ROW_W'(row_q + 1'b1);
	assign row_last      = (row_q == ROW_W'(NROWS - 1));
	assign pos_bit       = row_t'(1) << pos_q;

	// IDs at or beyond the limit in the last row never count as free.
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			row_mask[b] = ((CMP_W'(row_q) << ROW_SH) | CMP_W'(b)) < CMP_W'(ID_LIMIT);
			ge_mask[b]  = (ROW_SH'(b) >= pos_q);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data;
		rd_row  = row_nxt;
		if (state_q == ST_IDLE) begin
			rd_row = (s_axis_tuser == FUNC_RELEASE) ? held_row : hint_row;
		end
		if (state_q == ST_ASET) begin
			wr_en   = 1'b1;
			wr_data = rd_data | pos_bit;
		end else if (state_q == ST_RCLR) begin
			wr_en   = 1'b1;
			wr_data = rd_data & ~pos_bit;
		end
		if (state_q == ST_ASET) begin
			free_bits = ~wr_data & row_mask & ge_mask;
		end else begin
			free_bits = ~rd_data & row_mask;
		end
		hit = find_first(free_bits);
	end

	lfid_bitmap #(
		.NROWS (NROWS),
		.ROW_W (ROW_W)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_row  (rd_row),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_row  (row_q),
		.wr_data (wr_data),
		.ready   (map_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hint_q    <= ID_W'(1);
			row_q     <= '0;
			pos_q     <= '0;
			res_id_q  <= '0;
			res_st_q  <= STATUS_OK;
			m_valid_q <= 1'b0;
			m_id_q    <= '0;
			m_st_q    <= STATUS_OK;
		end else begin
			// The done state reloads the output register itself.
			if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser == FUNC_ALLOC) begin
							if (held != '0) begin
								res_id_q <= held;
								res_st_q <= STATUS_OK;
								state_q  <= ST_DONE;
							end else if (hint_full) begin
								res_id_q <= '0;
								res_st_q <= STATUS_EXHAUSTED;
								state_q  <= ST_DONE;
							end else begin
								res_id_q <= ID_BITS'(hint_q);
								res_st_q <= STATUS_OK;
								row_q    <= hint_row;
								pos_q    <= hint_q[ROW_SH-1:0];
								state_q  <= ST_ASET;
							end
						end else begin
							res_id_q <= '0;
							res_st_q <= STATUS_OK;
							if (held_in_range) begin
								row_q   <= held_row;
								pos_q   <= held[ROW_SH-1:0];
								state_q <= ST_RCLR;
								if (ID_W'(held) < hint_q) begin
									hint_q <= ID_W'(held);
								end
							end else begin
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_ASET, ST_SCAN: begin
					if (hit.hit) begin
						hint_q  <= ID_W'({row_q, hit.pos});
						state_q <= ST_DONE;
					end else if (row_last) begin
						hint_q  <= ID_W'(ID_LIMIT);
						state_q <= ST_DONE;
					end else begin
						row_q   <= row_nxt;
						state_q <= ST_SCAN;
					end
				end
				ST_RCLR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_id_q    <= res_id_q;
						m_st_q    <= res_st_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_id_q};
	assign m_axis_tuser  = m_st_q;

endmodule
